// File: rtl/assert_macros.svh
// Assertion helpers for the checker module spfm_checker; clk and rst_n come from the enclosing scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: rtl/spfm_pkg.sv
`timescale 1ns / 1ps
package spfm_pkg;
    localparam int WORD_W     = 32;
    localparam int EXP_W      = 8;
    localparam int MAN_W      = 23;
    localparam int HI_W       = 13;
    localparam int LO_W       = 11;
    localparam int SUM_W      = 26;
    localparam int EPRE_W     = 10;
    localparam int PIPE_DEPTH = 3;
    localparam logic [EPRE_W-1:0] EXP_BIAS_ADJ = 10'd129;
    localparam logic [SUM_W-1:0]  ROUND_ADD    = 26'd2;
    localparam logic [EXP_W-1:0]  EXP_MAX      = 8'd255;
    localparam logic [1:0] TOP_UNDER = 2'b01;
    localparam logic [1:0] TOP_OVER  = 2'b00;
endpackage

// File: rtl/spfm_datapath.sv
`timescale 1ns / 1ps
module spfm_datapath
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        in_valid,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        out_valid,
    output logic [31:0] product
);
    // stage 1: unpack and multiply
    logic                             s1_valid_reg;
    logic [2*spfm_pkg::HI_W-1:0]      hh_reg;
    logic [spfm_pkg::HI_W+spfm_pkg::LO_W-1:0] hl_reg, lh_reg;
    logic [spfm_pkg::EPRE_W-1:0]      e1_reg;
    logic                             sign1_reg, zero1_reg;
    // stage 2: sum
    logic                             s2_valid_reg;
    logic [spfm_pkg::SUM_W-1:0]       sum_reg;
    logic [spfm_pkg::EPRE_W-1:0]      e2_reg;
    logic                             sign2_reg, zero2_reg;
    // stage 3: pack
    logic                             s3_valid_reg;
    logic [31:0]                      prod_reg;

    logic [spfm_pkg::HI_W-1:0] ha, hb;
    logic [spfm_pkg::LO_W-1:0] la, lb;
    logic [spfm_pkg::SUM_W-1:0] sum_next;
    logic                       carry;
    logic [1:0]                 top;
    logic [spfm_pkg::MAN_W-1:0] man;
    logic [spfm_pkg::EXP_W-1:0] expo;
    logic [spfm_pkg::EPRE_W-1:0] e_inc;
    logic [31:0]                prod_next;

    assign ha = {(operand_a[30:23] != 8'd0), operand_a[22:11]};
    assign hb = {(operand_b[30:23] != 8'd0), operand_b[22:11]};
    assign la = operand_a[10:0];
    assign lb = operand_b[10:0];

    assign sum_next = spfm_pkg::SUM_W'(hh_reg)
                    + spfm_pkg::SUM_W'(hl_reg[23:11])
                    + spfm_pkg::SUM_W'(lh_reg[23:11])
                    + spfm_pkg::ROUND_ADD;

    assign carry = sum_reg[25];
    assign top   = e2_reg[8:7];
    assign man   = carry ? sum_reg[24:2] : sum_reg[23:1];
    assign e_inc = e2_reg + 10'd1;

    always_comb
    begin
        case (top)
            spfm_pkg::TOP_UNDER: expo = 8'd0;
            spfm_pkg::TOP_OVER:  expo = spfm_pkg::EXP_MAX;
            default:             expo = carry ? e_inc[7:0] : e2_reg[7:0];
        endcase
        prod_next = zero2_reg ? 32'd0 : {sign2_reg, expo, man};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hh_reg    <= ha * hb;
            hl_reg    <= ha * lb;
            lh_reg    <= la * hb;
            e1_reg    <= spfm_pkg::EPRE_W'(operand_a[30:23]) + spfm_pkg::EPRE_W'(operand_b[30:23])
                       + spfm_pkg::EXP_BIAS_ADJ;
            sign1_reg <= operand_a[31] ^ operand_b[31];
            zero1_reg <= (operand_a == 32'd0) || (operand_b == 32'd0);
            sum_reg   <= sum_next;
            e2_reg    <= e1_reg;
            sign2_reg <= sign1_reg;
            zero2_reg <= zero1_reg;
            prod_reg  <= prod_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign product   = prod_reg;
endmodule

// File: rtl/single_precision_float_multiply_top.sv
`timescale 1ns / 1ps
// channel  | dir | tdata                          | handshake
// s_axis   | in  | [31:0] operand_a [63:32] operand_b | tvalid/tready
// m_axis   | out | [31:0] product                  | tvalid/tready
// Three register stages; a result becomes valid once it reaches the third stage
// and leaves when m_axis_tready is high. One item per cycle unless m_axis stalls.
// Stages: partial-product multiply, sum, normalize and pack.
// Reset clears all valid bits; payload registers are not reset.
// A stall on m_axis freezes the whole pipeline; s_axis_tready drops with it
// only when the output stage holds an unaccepted result.
module single_precision_float_multiply_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // operand_a, operand_b
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // product
);
    logic advance;

    assign advance       = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = advance;

    spfm_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (s_axis_tvalid),
        .operand_a (s_axis_tdata[31:0]),
        .operand_b (s_axis_tdata[63:32]),
        .out_valid (m_axis_tvalid),
        .product   (m_axis_tdata)
    );
endmodule

// File: rtl/spfm_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spfm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    `ASSERT_CLK(a_hold_valid, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "output dropped")
    `ASSERT_CLK(a_hold_data, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata), "data moved")
    `ASSERT_NEVER(a_ready, m_axis_tvalid && !m_axis_tready && s_axis_tready, "input open in stall")
    `ASSERT_CLK(a_free, !m_axis_tvalid |-> s_axis_tready, "input refused while output empty")
endmodule

bind single_precision_float_multiply_top spfm_checker u_chk (.*);

// File: test/single_precision_float_multiply_top_test.sv
`timescale 1ns / 1ps
module single_precision_float_multiply_top_test;
    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    logic [63:0] operand_queue[$];
    logic [31:0] product_queue[$];
    int          errors = 0;
    int          sent = 0;
    int          received = 0;
    int          hold_cycles = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    bit          stim_done = 0;
    logic        s_axis_tready_q;

    single_precision_float_multiply_top dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    function automatic logic [31:0] fmul_product(input logic [31:0] a, input logic [31:0] b);
        logic [spfm_pkg::EXP_W-1:0]  ea;
        logic [spfm_pkg::EXP_W-1:0]  eb;
        logic [spfm_pkg::HI_W-1:0]   ha;
        logic [spfm_pkg::HI_W-1:0]   hb;
        logic [spfm_pkg::LO_W-1:0]   la;
        logic [spfm_pkg::LO_W-1:0]   lb;
        logic [31:0]                 sum;
        logic [spfm_pkg::EPRE_W-1:0] epre;
        logic [spfm_pkg::EPRE_W-1:0] einc;
        logic [spfm_pkg::MAN_W-1:0]  man;
        logic [spfm_pkg::EXP_W-1:0]  ex;
        logic                        carry;
        ea = a[30:23];
        eb = b[30:23];
        ha = {ea != '0, a[22:11]};
        hb = {eb != '0, b[22:11]};
        la = a[10:0];
        lb = b[10:0];
        sum = 32'(ha) * 32'(hb) + ((32'(ha) * 32'(lb)) >> spfm_pkg::LO_W)
            + ((32'(la) * 32'(hb)) >> spfm_pkg::LO_W) + 32'(spfm_pkg::ROUND_ADD);
        epre = spfm_pkg::EPRE_W'(ea) + spfm_pkg::EPRE_W'(eb) + spfm_pkg::EXP_BIAS_ADJ;
        einc = epre + spfm_pkg::EPRE_W'(1);
        carry = sum[25];
        man = carry ? sum[24:2] : sum[23:1];
        if (epre[8:7] == spfm_pkg::TOP_UNDER)
            ex = '0;
        else if (epre[8:7] == spfm_pkg::TOP_OVER)
            ex = spfm_pkg::EXP_MAX;
        else
            ex = carry ? einc[7:0] : epre[7:0];
        if (a == 32'd0 || b == 32'd0)
            return 32'd0;
        return {a[31] ^ b[31], ex, man};
    endfunction

    function automatic logic [31:0] random_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v[30:23] = '0;
            1: v[30:23] = 8'hFF;
            2: v = '0;
            3: v[30:23] = 8'(127 + $urandom_range(0, 8) - 4);
            default: ;
        endcase
        return v;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        logic [31:0] edges[10];
        edges = '{32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h3F80_0000,
                  32'h0000_0001, 32'h007F_FFFF, 32'h7F80_0000, 32'h3FFF_FFFF, 32'h4000_07FF};
        for (int i = 0; i < 10; i++)
            operand_queue.push_back({random_float(), edges[i]});
        operand_queue.push_back({32'h3F80_0000, 32'h3F80_0000});
        operand_queue.push_back({32'h0080_0000, 32'h0080_0000});
        operand_queue.push_back({32'h7F00_0000, 32'h7F00_0000});
        operand_queue.push_back({32'h3F80_0000, 32'h4000_0000});
        operand_queue.push_back({32'h7FFF_FFFF, 32'h4000_0000});
        operand_queue.push_back({32'h0000_0000, 32'hFFFF_FFFF});
        operand_queue.push_back({32'hBFFF_FFFF, 32'hBFFF_FFFF});
        operand_queue.push_back({32'h0000_07FF, 32'h007F_F800});
        for (int i = 0; i < 500; i++)
            operand_queue.push_back({random_float(), random_float()});
    end

    initial
    begin
        rst_n = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 0;
            s_axis_tdata <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready_q)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 0;
            end
            else if (operand_queue.size() > 0)
            begin
                s_axis_tvalid <= 1;
                s_axis_tdata <= operand_queue.pop_front();
                send_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                            ($urandom_range(0, 9) == 0 ? $urandom_range(5, 20)
                                                       : $urandom_range(1, 2));
            end
            else
            begin
                s_axis_tvalid <= 0;
                stim_done <= 1;
            end
        end
    end

    always @(posedge clk)
    begin
        s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            product_queue.push_back(fmul_product(s_axis_tdata[31:0], s_axis_tdata[63:32]));
            sent <= sent + 1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 0;
        else if (sent > 30 && sent < 60 && hold_cycles == 0 && received < 40)
        begin
            hold_cycles <= 40;
            m_axis_tready <= 0;
        end
        else if (hold_cycles > 1)
        begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            if (hold_cycles == 1)
                hold_cycles <= -1;
            m_axis_tready <= 0;
        end
        else
        begin
            if (hold_cycles == 1)
                hold_cycles <= -1;
            m_axis_tready <= 1;
            if ((sent / 100) % 2 == 1)
                recv_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                            ($urandom_range(0, 19) == 0 ? $urandom_range(5, 20)
                                                        : $urandom_range(1, 2));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            received <= received + 1;
            if (product_queue.size() == 0)
            begin
                $display("%0t: unexpected product, expected none, actual %h",
                         $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                logic [31:0] want;
                want = product_queue.pop_front();
                if (want !== m_axis_tdata)
                begin
                    $display("%0t: product mismatch, expected %h, actual %h",
                             $time, want, m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        wait (stim_done && operand_queue.size() == 0);
        wait (product_queue.size() == 0 && !s_axis_tvalid);
        repeat (spfm_pkg::PIPE_DEPTH + 4) @(posedge clk);
        $display("Multiplied %0d operand pairs: zero, subnormal, overflow and underflow",
                 sent);
        $display("exponents, with random stalls on both sides and one long output hold.");
        if (errors == 0 && product_queue.size() == 0)
            $display("single_precision_float_multiply_top_test passed");
        else
            $display("single_precision_float_multiply_top_test failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("single_precision_float_multiply_top_test failed");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/spfm_pkg.sv
rtl/spfm_datapath.sv
rtl/single_precision_float_multiply_top.sv
rtl/spfm_checker.sv
test/single_precision_float_multiply_top_test.sv
